// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL; clocked on i_clk, disabled during i_rst_n low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/iplv_pkg.sv
// Types and constants for the IP literal validator.
`timescale 1ns / 1ps
`default_nettype none

package iplv_pkg;

    typedef enum logic [1:0] {
        KIND_REJECT = 2'd0,
        KIND_IPV4   = 2'd1,
        KIND_IPV6   = 2'd2
    } t_kind;

    localparam logic [15:0] CHAR_DOT    = 16'h002E;
    localparam logic [15:0] CHAR_COLON  = 16'h003A;
    localparam logic [15:0] CHAR_DIG_LO = 16'h0030;
    localparam logic [15:0] CHAR_DIG_HI = 16'h0039;
    localparam logic [15:0] CHAR_LC_LO  = 16'h0061;
    localparam logic [15:0] CHAR_LC_HI  = 16'h0066;
    localparam logic [15:0] CHAR_UC_LO  = 16'h0041;
    localparam logic [15:0] CHAR_UC_HI  = 16'h0046;

    localparam logic [1:0]  QUAD_LAST_GROUP = 2'd3;
    localparam logic [1:0]  QUAD_MAX_DIGITS = 2'd3;
    localparam logic [11:0] OCTET_MAX       = 12'd255;

    localparam logic [3:0]  COLON_MIN = 4'd2;
    localparam logic [3:0]  COLON_MAX = 4'd7;
    localparam logic [3:0]  COLON_SAT = 4'd8;

endpackage

`default_nettype wire

// File: hdl/ip_literal_validator_top.sv
// IP literal validator: streaming dotted-quad and IPv6 checkers with a two-slot result buffer.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+-----------------------------------------
// input    | in  | i_valid / o_stall  | i_code_unit[15:0], i_last, i_empty_string
// result   | out | o_valid / i_stall  | o_accepted, o_address_kind[1:0]
//
// One code unit is taken per cycle while o_stall is low; the checker state
// updates at the accepting edge. The verdict of the last code unit is registered.
// Results sit in an output register backed by a skid slot; o_stall rises only
// while both are full, so a stalled verdict never blocks the next string.
// i_rst_n is synchronous, active low, and clears checker state and both slots.

module ip_literal_validator_top
    import iplv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_last,
    input  wire logic        i_empty_string,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_accepted,
    output logic [1:0]       o_address_kind
);

`include "assert_macros.svh"

    // ---------------------------------------------------------------------
    // Checker state
    // ---------------------------------------------------------------------
    logic [1:0] r_group_count, n_group_count;
    logic [1:0] r_digit_count, n_digit_count;
    logic [7:0] r_group_value, n_group_value;
    logic       r_quad_failed, n_quad_failed;
    logic [3:0] r_colon_count, n_colon_count;
    logic       r_hex_failed,  n_hex_failed;
    logic       r_saw_colon,   n_saw_colon;

    // Result slots
    logic       r_out_valid,  n_out_valid;
    logic       r_out_ok,     n_out_ok;
    t_kind      r_out_kind,   n_out_kind;
    logic       r_skid_valid, n_skid_valid;
    logic       r_skid_ok,    n_skid_ok;
    t_kind      r_skid_kind,  n_skid_kind;

    logic       take;       // input transaction completes this edge
    logic       out_pop;    // result transaction completes this edge
    logic       res_push;   // new verdict produced this edge
    logic       res_ok;
    t_kind      res_kind;
    logic       is_digit;
    logic       is_hex_alpha;
    logic [11:0] octet_next;

    assign o_stall = r_skid_valid;
    assign take    = i_valid && !o_stall;
    assign out_pop = r_out_valid && !i_stall;
    assign res_push = take && i_last;

    assign o_valid        = r_out_valid;
    assign o_accepted     = r_out_ok;
    assign o_address_kind = r_out_kind;

    // Character classes
    always_comb begin
        is_digit     = i_code_unit inside {[CHAR_DIG_LO:CHAR_DIG_HI]};
        is_hex_alpha = i_code_unit inside {[CHAR_LC_LO:CHAR_LC_HI], [CHAR_UC_LO:CHAR_UC_HI]};
        // group_value * 10 + digit, done as two shifts and adds
        octet_next   = {1'b0, r_group_value, 3'b000} + {3'b000, r_group_value, 1'b0}
                       + {8'd0, i_code_unit[3:0]};
    end

    // ---------------------------------------------------------------------
    // Per-character update of both checkers
    // ---------------------------------------------------------------------
    always_comb begin
        n_group_count = r_group_count;
        n_digit_count = r_digit_count;
        n_group_value = r_group_value;
        n_quad_failed = r_quad_failed;
        n_colon_count = r_colon_count;
        n_hex_failed  = r_hex_failed;
        n_saw_colon   = r_saw_colon;

        if (!i_empty_string) begin
            // dotted-quad checker; frozen once failed
            if (!r_quad_failed) begin
                if (i_code_unit == CHAR_DOT) begin
                    if (r_digit_count == 2'd0 || r_group_count == QUAD_LAST_GROUP) begin
                        n_quad_failed = 1'b1;
                    end else begin
                        n_group_count = r_group_count + 2'd1;
                        n_digit_count = 2'd0;
                        n_group_value = 8'd0;
                    end
                end else if (is_digit) begin
                    if (r_digit_count == QUAD_MAX_DIGITS || octet_next > OCTET_MAX) begin
                        n_quad_failed = 1'b1;
                    end else begin
                        n_digit_count = r_digit_count + 2'd1;
                        n_group_value = octet_next[7:0];
                    end
                end else begin
                    n_quad_failed = 1'b1;
                end
            end

            // IPv6 alphabet and colon count
            if (i_code_unit == CHAR_COLON) begin
                n_saw_colon = 1'b1;
                if (r_colon_count < COLON_SAT) begin
                    n_colon_count = r_colon_count + 4'd1;
                end
            end else if (!(i_code_unit == CHAR_DOT || is_digit || is_hex_alpha)) begin
                n_hex_failed = 1'b1;
            end
        end
    end

    // Verdict from the state after this character
    always_comb begin
        res_ok = 1'b0;
        if (!i_empty_string) begin
            if (n_saw_colon) begin
                res_ok = !n_hex_failed && n_colon_count >= COLON_MIN
                         && n_colon_count <= COLON_MAX;
            end else begin
                res_ok = !n_quad_failed && n_group_count == QUAD_LAST_GROUP
                         && n_digit_count != 2'd0;
            end
        end
        if (!res_ok) begin
            res_kind = KIND_REJECT;
        end else if (n_saw_colon) begin
            res_kind = KIND_IPV6;
        end else begin
            res_kind = KIND_IPV4;
        end
    end

    // ---------------------------------------------------------------------
    // Result buffer: output register plus skid slot
    // ---------------------------------------------------------------------
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_ok     = r_out_ok;
        n_out_kind   = r_out_kind;
        n_skid_valid = r_skid_valid;
        n_skid_ok    = r_skid_ok;
        n_skid_kind  = r_skid_kind;

        if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                // skid full means input was stalled, so no new verdict this edge
                n_out_valid  = 1'b1;
                n_out_ok     = r_skid_ok;
                n_out_kind   = r_skid_kind;
                n_skid_valid = 1'b0;
            end else if (res_push) begin
                n_out_valid = 1'b1;
                n_out_ok    = res_ok;
                n_out_kind  = res_kind;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (res_push) begin
            n_skid_valid = 1'b1;
            n_skid_ok    = res_ok;
            n_skid_kind  = res_kind;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= 2'd0;
            r_digit_count <= 2'd0;
            r_group_value <= 8'd0;
            r_quad_failed <= 1'b0;
            r_colon_count <= 4'd0;
            r_hex_failed  <= 1'b0;
            r_saw_colon   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            if (res_push) begin
                // string closed: start the next one clean
                r_group_count <= 2'd0;
                r_digit_count <= 2'd0;
                r_group_value <= 8'd0;
                r_quad_failed <= 1'b0;
                r_colon_count <= 4'd0;
                r_hex_failed  <= 1'b0;
                r_saw_colon   <= 1'b0;
            end else if (take) begin
                r_group_count <= n_group_count;
                r_digit_count <= n_digit_count;
                r_group_value <= n_group_value;
                r_quad_failed <= n_quad_failed;
                r_colon_count <= n_colon_count;
                r_hex_failed  <= n_hex_failed;
                r_saw_colon   <= n_saw_colon;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_ok    <= n_out_ok;
        r_out_kind  <= n_out_kind;
        r_skid_ok   <= n_skid_ok;
        r_skid_kind <= n_skid_kind;
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `ASSERT_IMPLIES(a_skid_behind_out, r_skid_valid, r_out_valid)
    `ASSERT_IMPLIES(a_verdict_kind_match, r_out_valid,
        r_out_ok == (r_out_kind != KIND_REJECT))
    `ASSERT_ALWAYS(a_colon_saturates, r_colon_count <= COLON_SAT)
    `ASSERT_NEXT(a_state_clears_on_last, take && i_last,
        r_group_count == 2'd0 && r_colon_count == 4'd0 && !r_saw_colon && !r_quad_failed)

endmodule

`default_nettype wire
